[hw/rtl/mtp_pkg.sv]
// Package for the MT19937 generator: sizes, constants, format codes, shared types
// and the tempering and output-format functions.
// No dependencies; every other file of the block imports it.
package mtp_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int POS_W        = $clog2(STATE_WORDS);

    localparam logic [31:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [3:0]       t_fmt;

    localparam t_fmt FMT_U32    = 4'd0;
    localparam t_fmt FMT_I8     = 4'd1;
    localparam t_fmt FMT_I16    = 4'd2;
    localparam t_fmt FMT_I32    = 4'd3;
    localparam t_fmt FMT_I64    = 4'd4;
    localparam t_fmt FMT_U8     = 4'd5;
    localparam t_fmt FMT_U16    = 4'd6;
    localparam t_fmt FMT_U64    = 4'd7;
    localparam t_fmt FMT_FRAC32 = 4'd8;
    localparam t_fmt FMT_FRAC53 = 4'd9;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_TW1,
        S_TW2,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic [63:0] value;
        logic        valid_draw;
    } t_result;

    typedef struct packed {
        logic        we;
        t_pos        waddr;
        logic [31:0] wdata;
        t_pos        raddr_nxt;
        t_pos        raddr_far;
    } t_ram_req;

    function automatic t_pos f_pos_inc(input t_pos p);
        t_pos r;
        if (p == t_pos'(STATE_WORDS - 1)) begin
            r = '0;
        end else begin
            r = p + t_pos'(1);
        end
        return r;
    endfunction

    function automatic t_pos f_pos_far(input t_pos p);
        logic [POS_W:0] s;
        logic [POS_W:0] d;
        s = {1'b0, p} + (POS_W+1)'(TWIST_OFFSET);
        d = s - (POS_W+1)'(STATE_WORDS);
        return (s < (POS_W+1)'(STATE_WORDS)) ? s[POS_W-1:0] : d[POS_W-1:0];
    endfunction

    function automatic logic [31:0] f_temper(input logic [31:0] x);
        logic [31:0] y;
        y = x;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic f_two_words(input t_fmt f);
        return (f == FMT_I64) || (f == FMT_U64) || (f == FMT_FRAC53);
    endfunction

    function automatic logic [63:0] f_format(input t_fmt f, input logic [31:0] w,
                                             input logic [31:0] v);
        logic [63:0] r;
        case (f)
            FMT_I8:     r = {57'b0, w[6:0]};
            FMT_I16:    r = {49'b0, w[14:0]};
            FMT_I32:    r = {33'b0, w[30:0]};
            FMT_I64:    r = {1'b0, w[30:0], v};
            FMT_U8:     r = {56'b0, w[7:0]};
            FMT_U16:    r = {48'b0, w[15:0]};
            FMT_U64:    r = {w, v};
            FMT_FRAC53: r = {11'b0, w[31:5], v[31:6]};
            default:    r = {32'b0, w};
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mersenne_twister_prng.sv]
// Top level of the MT19937 generator: format register, output register and
// the key store with its sequencer. Depends on mtp_pkg, mtp_ram and mtp_core.
//
// An input word with i_op high reseeds the generator from i_seed_value and
// gives no result; an input word with i_op low draws one value in the format
// held in the configuration register (written through i_cfg_valid/o_cfg_ready;
// the user is to write it only while the block is idle, and the block itself
// does not enforce this; o_cfg_ready is always high). A draw passes through
// state S_TW1, and for the 64-bit and 53-bit formats also S_TW2, before its
// result goes to the output register, and o_stall stays high until then, so a
// new input word is not taken before the last draw is through; each generated
// word is twisted and written back to the key store. A reseed walks all 624
// words, one word per cycle through the seeding multiplier, stalling the input.
// A draw before the first seed returns a zero value with o_valid_draw low.
// After reset the block is unseeded and the format is the raw 32-bit word.
// The output register holds one finished word; while i_stall is high a
// further draw is computed and then waits inside the block, with o_stall high.
module mersenne_twister_prng (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [31:0] i_seed_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_value,
    output logic        o_valid_draw,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import mtp_pkg::*;

    t_fmt        r_fmt;
    logic        r_oval;
    t_result     r_out;
    logic        out_free;
    logic        res_load;
    t_result     res;
    t_ram_req    ram_req;
    logic [31:0] rdata_nxt;
    logic [31:0] rdata_far;

    assign o_cfg_ready  = 1'b1;
    assign out_free     = !r_oval || !i_stall;
    assign o_valid      = r_oval;
    assign o_value      = r_out.value;
    assign o_valid_draw = r_out.valid_draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt  <= FMT_U32;
            r_oval <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_fmt <= i_cfg_data;
            end
            if (res_load) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
        if (res_load) begin
            r_out <= res;
        end
    end

    mtp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_seed_value (i_seed_value),
        .o_stall      (o_stall),
        .i_fmt        (r_fmt),
        .i_out_free   (out_free),
        .o_res_load   (res_load),
        .o_res        (res),
        .o_ram_req    (ram_req),
        .i_rdata_nxt  (rdata_nxt),
        .i_rdata_far  (rdata_far)
    );

    mtp_ram u_ram (
        .i_clk       (i_clk),
        .i_req       (ram_req),
        .o_rdata_nxt (rdata_nxt),
        .o_rdata_far (rdata_far)
    );

endmodule

[hw/rtl/mtp_ram.sv]
// Key store of the generator: one write port and two registered read ports.
// Depends on mtp_pkg.
module mtp_ram (
    input  logic              i_clk,
    input  mtp_pkg::t_ram_req i_req,
    output logic [31:0]       o_rdata_nxt,
    output logic [31:0]       o_rdata_far
);
    import mtp_pkg::*;

    logic [31:0] mem [STATE_WORDS];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata_nxt <= mem[i_req.raddr_nxt];
        o_rdata_far <= mem[i_req.raddr_far];
    end

endmodule

[hw/rtl/mtp_core.sv]
// Sequencer of the generator: seeding walk, per-word twist with write-back,
// tempering and output formatting. Depends on mtp_pkg; drives mtp_ram.
module mtp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  logic [31:0]        i_seed_value,
    output logic               o_stall,
    input  mtp_pkg::t_fmt      i_fmt,
    input  logic               i_out_free,
    output logic               o_res_load,
    output mtp_pkg::t_result   o_res,
    output mtp_pkg::t_ram_req  o_ram_req,
    input  logic [31:0]        i_rdata_nxt,
    input  logic [31:0]        i_rdata_far
);
    import mtp_pkg::*;

    t_state      r_state, n_state;
    t_pos        r_pos, n_pos;
    t_pos        r_idx, n_idx;
    logic        r_seeded, n_seeded;
    logic [31:0] r_seed, n_seed;
    logic [31:0] r_cur, n_cur;
    logic [31:0] r_w, n_w;
    t_result     r_res, n_res;

    logic [31:0] y;
    logic [31:0] twisted;
    logic [31:0] tempered;
    logic [31:0] seed_mix;
    logic        accept;
    logic        have_res;
    t_result     res;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign y        = (r_cur & HIGH_BIT) | (i_rdata_nxt & LOW_BITS);
    assign twisted  = i_rdata_far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'b0);
    assign tempered = f_temper(twisted);
    assign seed_mix = r_seed ^ (r_seed >> 30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_seeded <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_seeded <= n_seeded;
        end
        r_idx  <= n_idx;
        r_seed <= n_seed;
        r_cur  <= n_cur;
        r_w    <= n_w;
        r_res  <= n_res;
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_idx    = r_idx;
        n_seeded = r_seeded;
        n_seed   = r_seed;
        n_cur    = r_cur;
        n_w      = r_w;
        n_res    = r_res;
        have_res = 1'b0;
        res      = r_res;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_pos;
        o_ram_req.wdata = twisted;
        o_stall    = (r_state != S_IDLE);
        o_res_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_SEED) begin
                        n_seed  = i_seed_value;
                        n_idx   = '0;
                        n_state = S_SEED;
                    end else if (r_seeded) begin
                        n_state = S_TW1;
                    end else begin
                        have_res = 1'b1;
                        res      = '{value: 64'b0, valid_draw: 1'b0};
                    end
                end
            end
            S_SEED: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_idx;
                o_ram_req.wdata = r_seed;
                n_seed = SEED_MULT * seed_mix + 32'(r_idx) + 32'd1;
                n_idx  = r_idx + t_pos'(1);
                if (r_idx == '0) begin
                    n_cur = r_seed;
                end
                if (r_idx == t_pos'(STATE_WORDS - 1)) begin
                    n_pos    = '0;
                    n_seeded = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_TW1: begin
                o_ram_req.we = 1'b1;
                n_cur = i_rdata_nxt;
                n_pos = f_pos_inc(r_pos);
                if (f_two_words(i_fmt)) begin
                    n_w     = tempered;
                    n_state = S_TW2;
                end else begin
                    have_res = 1'b1;
                    res      = '{value: f_format(i_fmt, tempered, 32'b0), valid_draw: 1'b1};
                end
            end
            S_TW2: begin
                o_ram_req.we = 1'b1;
                n_cur    = i_rdata_nxt;
                n_pos    = f_pos_inc(r_pos);
                have_res = 1'b1;
                res      = '{value: f_format(i_fmt, r_w, tempered), valid_draw: 1'b1};
            end
            S_PUSH: begin
                if (i_out_free) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (have_res) begin
            n_res = res;
            if (i_out_free) begin
                o_res_load = 1'b1;
                n_state    = S_IDLE;
            end else begin
                n_state = S_PUSH;
            end
        end

        o_res = res;
        o_ram_req.raddr_nxt = f_pos_inc(n_pos);
        o_ram_req.raddr_far = f_pos_far(n_pos);
    end

endmodule

[test/tb.sv]
// Testbench for mersenne_twister_prng: directed and random seed and draw words against
// an in-bench MT19937 predictor, under four mixes of sender idling and receiver stalls.
// Depends on mtp_pkg and the RTL of the block only.
module tb;
    import mtp_pkg::*;

    localparam int KEY_WORDS    = 624;
    localparam int DRAIN_CYCLES = 640;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_WORDS  = 60;
    localparam int PHASES       = 10;

    typedef struct packed {
        logic [63:0] value;
        logic        drawn;
    } t_draw;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        i_op         = OP_DRAW;
    logic [31:0] i_seed_value = '0;
    logic        i_stall      = 1'b0;
    logic        i_cfg_valid  = 1'b0;
    logic [3:0]  i_cfg_data   = '0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_value;
    logic        o_valid_draw;
    logic        o_cfg_ready;

    logic [31:0] key_words [KEY_WORDS];
    int          key_pos    = KEY_WORDS;
    logic        is_seeded  = 1'b0;
    t_fmt        fmt_reg    = FMT_U32;
    t_draw       pending_draws [$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int checked_count = 0;
    int draw_count    = 0;
    int seed_count    = 0;
    int cycle_count   = 0;

    mersenne_twister_prng u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_seed_value (i_seed_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_valid_draw (o_valid_draw),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void reseed_keys(input logic [31:0] seed);
        logic [31:0] k;
        k = seed;
        for (int i = 0; i < KEY_WORDS; i++) begin
            key_words[i] = k;
            k = SEED_MULT * (k ^ (k >> 30)) + 32'(i + 1);
        end
        key_pos   = KEY_WORDS;
        is_seeded = 1'b1;
    endfunction

    function automatic void regen_keys();
        logic [31:0] y;
        for (int i = 0; i < KEY_WORDS; i++) begin
            y = (key_words[i] & HIGH_BIT) | (key_words[(i + 1) % KEY_WORDS] & LOW_BITS);
            key_words[i] = key_words[(i + TWIST_OFFSET) % KEY_WORDS] ^ (y >> 1)
                           ^ (y[0] ? TWIST_MATRIX : 32'h0);
        end
        key_pos = 0;
    endfunction

    function automatic logic [31:0] pull_word();
        logic [31:0] y;
        if (key_pos >= KEY_WORDS) begin
            regen_keys();
        end
        y = key_words[key_pos];
        key_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic t_draw forecast_draw();
        t_draw       d;
        logic [31:0] w;
        logic [31:0] v;
        d.value = '0;
        d.drawn = 1'b0;
        if (!is_seeded) begin
            return d;
        end
        d.drawn = 1'b1;
        w = pull_word();
        case (fmt_reg)
            FMT_I8:  d.value = 64'(w & 32'h0000_007f);
            FMT_I16: d.value = 64'(w & 32'h0000_7fff);
            FMT_I32: d.value = 64'(w & LOW_BITS);
            FMT_U8:  d.value = 64'(w & 32'h0000_00ff);
            FMT_U16: d.value = 64'(w & 32'h0000_ffff);
            FMT_I64: begin
                v = pull_word();
                d.value = {32'(w & LOW_BITS), v};
            end
            FMT_U64: begin
                v = pull_word();
                d.value = {w, v};
            end
            FMT_FRAC53: begin
                v = pull_word();
                d.value = (64'(w >> 5) << 26) | 64'(v >> 6);
            end
            default: d.value = 64'(w);
        endcase
        return d;
    endfunction

    task automatic send_word(input logic op, input logic [31:0] seed);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid      = 1'b1;
        i_op         = op;
        i_seed_value = seed;
        do @(posedge i_clk); while (o_stall);
        if (op == OP_SEED) begin
            reseed_keys(seed);
            seed_count++;
        end else begin
            pending_draws.push_back(forecast_draw());
            draw_count++;
        end
    endtask

    // A reseed gives no result, so the drain also covers a full seeding walk.
    task automatic drain_block();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_format(input t_fmt f);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = f;
        do @(posedge i_clk); while (!o_cfg_ready);
        fmt_reg = f;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_unseeded_draws();
        send_word(OP_DRAW, 32'hffff_ffff);
        send_word(OP_DRAW, 32'h0);
        drain_block();
        set_format(FMT_U64);
        send_word(OP_DRAW, $urandom());
        drain_block();
    endtask

    task automatic test_seed_extremes();
        send_word(OP_SEED, 32'h0);
        send_word(OP_DRAW, $urandom());
        send_word(OP_SEED, 32'hffff_ffff);
        send_word(OP_DRAW, $urandom());
        send_word(OP_SEED, 32'd5489);
        send_word(OP_DRAW, $urandom());
        drain_block();
    endtask

    // Codes above the frac53 format must behave as the raw word.
    task automatic test_each_format();
        for (int f = 0; f < 16; f++) begin
            set_format(t_fmt'(f));
            send_word(OP_DRAW, $urandom());
            drain_block();
        end
    endtask

    // The first phases draw two words per item from one seed, so the store twists again.
    task automatic test_random_streams();
        t_fmt wide_fmts [6] = '{FMT_U64, FMT_FRAC53, FMT_I64, FMT_U64, FMT_I64, FMT_FRAC53};
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            set_format(ph < 6 ? wide_fmts[ph] : t_fmt'($urandom_range(0, 15)));
            if (ph == 0 || (ph >= 6 && $urandom_range(0, 1) == 1)) begin
                send_word(OP_SEED, $urandom());
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph >= 6 && $urandom_range(0, 99) < 4) begin
                    send_word(OP_SEED, $urandom());
                end else begin
                    send_word(OP_DRAW, $urandom());
                end
            end
            drain_block();
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_draws.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result, expected none, actual value %h valid_draw %b",
                         $time, o_value, o_valid_draw);
            end else begin
                want = pending_draws.pop_front();
                checked_count++;
                if (want.value !== o_value) begin
                    fail_count++;
                    $display("%0t: value mismatch, expected %h, actual %h",
                             $time, want.value, o_value);
                end
                if (want.drawn !== o_valid_draw) begin
                    fail_count++;
                    $display("%0t: valid_draw mismatch, expected %b, actual %b",
                             $time, want.drawn, o_valid_draw);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_draws.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_unseeded_draws();
        test_seed_extremes();
        test_each_format();
        test_random_streams();
        $display("Sent %0d draws and %0d reseeds; checked %0d results over all 16 format codes,",
                 draw_count, seed_count, checked_count);
        $display("a draw before seeding, repeated twists and four idling mixes, in %0d cycles.",
                 cycle_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
